FILE: hw/rtl/sbf_pkg.sv
`default_nettype none
package sbf_pkg;

  localparam int unsigned IN_W       = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MAX_BYTES  = 4;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned PCNT_W     = 3;
  localparam int unsigned CHIDX_W    = 4;
  localparam int unsigned ACC_W      = 24;
  localparam int unsigned TOTAL_W    = 5;
  localparam int unsigned NCAND      = 6;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
  localparam logic [BYTE_W-1:0] FLAGS_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] END_BYTE    = 8'h00;

  // One run of bytes caused by a single request, packed from slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [MAX_BYTES-1:0]             end_mask;
    logic [CNT_W-1:0]                 count;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } push_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sbus_frame_encoder.sv
// SBUS frame encoder: packs servo channel values into the bytes of a frame.
// Input channel: one request per channel value (in_valid / in_ready,
// in_channel_value). Channel position follows an internal counter that
// starts at the first channel after reset and wraps after CHANNELS requests.
// Output channel: one byte per request (out_valid / out_ready), marked with
// out_last_in_run on the final byte caused by an input request and with
// out_frame_end on the closing end byte. A frame is a 0x0F header, the
// channel bits packed LSB-first, a flags byte and an end byte (25 bytes
// with the defaults). Each input request yields one to four bytes.
// Path: an accepted request's run is written into the run queue, and its
// first byte then moves into the output register once that register is free.
// Throughput: the output register moves one byte per cycle while out_ready
// is high and a run is queued; the input takes one request per cycle while
// the two-entry run queue has room, so the sustained rate is set by the
// byte output at 25 bytes per 16 requests.
// Reset (synchronous, active low) empties the queue, drops the output byte
// and restarts at the first channel of a frame. When the receiver stalls the
// output byte holds, the queue fills and in_ready drops once it is full.
`default_nettype none
module sbus_frame_encoder
  import sbf_pkg::*;
#(
  parameter int unsigned CHANNELS         = 16,
  parameter int unsigned BITS_PER_CHANNEL = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   in_channel_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_frame_byte,
  output logic                   out_last_in_run,
  output logic                   out_frame_end
);

  push_t   push;
  q_stat_t q_stat;
  run_t    head;
  logic    pop;

  // Front: classify the request and pack its run of bytes.
  sbf_front #(
    .CHANNELS         (CHANNELS),
    .BITS_PER_CHANNEL (BITS_PER_CHANNEL)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_value (in_channel_value),
    .q_stat           (q_stat),
    .push             (push)
  );

  // Short run queue: decouple the front from output stalls.
  sbf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Back: serialize each run one byte per cycle into the output register while out_ready is high.
  sbf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_byte  (out_frame_byte),
    .out_last_in_run (out_last_in_run),
    .out_frame_end   (out_frame_end)
  );

  // The end byte always closes the run of its request.
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last_in_run && (out_frame_byte == END_BYTE))
    else $error("frame end not on the last byte of a run");

  // Queue occupancy never exceeds its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("run queue overflow");

  // Every queued run carries between one and four bytes.
  a_run_size: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (head.count != '0) && (head.count <= CNT_W'(MAX_BYTES)))
    else $error("bad run length at queue head");

  // A request accepted into an empty pipeline has its run written into the queue
  // and its first byte then loaded into the output register, raising out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && q_stat.empty && !out_valid |=> ##1 out_valid)
    else $error("first byte of a run is late");

endmodule
`default_nettype wire

FILE: hw/rtl/sbf_front.sv
`default_nettype none
module sbf_front
  import sbf_pkg::*;
#(
  parameter int unsigned CHANNELS         = 16,
  parameter int unsigned BITS_PER_CHANNEL = 11
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [IN_W-1:0] in_channel_value,
  input  wire q_stat_t         q_stat,
  output push_t                push
);

  localparam logic [IN_W-1:0] VAL_MASK = (BITS_PER_CHANNEL >= IN_W) ? {IN_W{1'b1}} :
                                         IN_W'((1 << BITS_PER_CHANNEL) - 1);
  localparam logic [CHIDX_W-1:0] LAST_IDX = CHIDX_W'(CHANNELS - 1);
  localparam logic [TOTAL_W-1:0] BPC      = TOTAL_W'(BITS_PER_CHANNEL);

  logic [PEND_W-1:0]    pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  logic [CHIDX_W-1:0]   ch_idx_r, ch_idx_nxt;

  logic [IN_W-1:0]      value;
  logic [ACC_W-1:0]     acc;
  logic [TOTAL_W-1:0]   total;
  logic [1:0]           nfull;
  logic [2:0]           rem;
  logic                 last_ch;
  logic [BYTE_W-1:0]    tail_byte;
  logic                 accept;

  logic [NCAND-1:0]               cand_v;
  logic [NCAND-1:0]               cand_e;
  logic [NCAND-1:0][BYTE_W-1:0]   cand_b;
  logic [CNT_W-1:0]               n;
  run_t                           run;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    value     = in_channel_value & VAL_MASK;
    acc       = ACC_W'(pend_bits_r) | (ACC_W'(value) << pend_cnt_r);
    total     = TOTAL_W'(pend_cnt_r) + BPC;
    nfull     = total[4:3];
    rem       = total[2:0];
    last_ch   = ch_idx_r >= LAST_IDX;
    case (nfull)
      2'd0:    tail_byte = acc[7:0];
      2'd1:    tail_byte = acc[15:8];
      2'd2:    tail_byte = acc[23:16];
      default: tail_byte = '0;
    endcase
  end

  // Candidate bytes in stream order: header, two full bytes, padded tail, flags, end.
  always_comb begin
    cand_v = {last_ch, last_ch, last_ch && (rem != 3'd0),
              nfull == 2'd2, nfull != 2'd0, ch_idx_r == '0};
    cand_b = {END_BYTE, FLAGS_BYTE, tail_byte, acc[15:8], acc[7:0], HEADER_BYTE};
    cand_e = {1'b1, 5'b0};
    run    = '0;
    n      = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && (n < CNT_W'(MAX_BYTES))) begin
        run.bytes[n[SLOT_W-1:0]]    = cand_b[i];
        run.end_mask[n[SLOT_W-1:0]] = cand_e[i];
        n = n + 1'b1;
      end
    end
    run.count = n;
  end

  assign push.valid = accept && (n != '0);
  assign push.run   = run;

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    ch_idx_nxt    = ch_idx_r;
    if (accept) begin
      if (last_ch) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
        ch_idx_nxt    = '0;
      end else begin
        pend_bits_nxt = tail_byte[PEND_W-1:0];
        pend_cnt_nxt  = rem;
        ch_idx_nxt    = ch_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      ch_idx_r    <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      ch_idx_r    <= ch_idx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sbf_queue.sv
`default_nettype none
module sbf_queue
  import sbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output run_t       head,
  output q_stat_t    q_stat
);

  run_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.count = cnt_r;
  assign head         = mem[rd_ptr_r];

  assign do_push = push.valid && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sbf_back.sv
`default_nettype none
module sbf_back
  import sbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire run_t        head,
  input  wire q_stat_t     q_stat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [BYTE_W-1:0] out_frame_byte,
  output logic             out_last_in_run,
  output logic             out_frame_end
);

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r, end_r;
  logic              load, fire, last_sel;

  assign load     = !out_valid_r || out_ready;
  assign fire     = load && !q_stat.empty;
  assign last_sel = (CNT_W'(idx_r) + 1'b1) >= head.count;
  assign pop      = fire && last_sel;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
    end
    if (fire) begin
      idx_nxt = last_sel ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= head.bytes[idx_r];
      last_r <= last_sel;
      end_r  <= head.end_mask[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_byte  = byte_r;
  assign out_last_in_run = last_r;
  assign out_frame_end   = end_r;

endmodule
`default_nettype wire
